// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// the enclosing scope must provide clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slfr check failed");

// next-cycle implication, disabled during reset
`define SLFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slfr check failed");

`endif

// File: rtl/core/slfr_pkg.sv
`default_nettype none

package slfr_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hEA;
    localparam logic [7:0]  SYNC_SECOND = 8'hEF;
    localparam logic [15:0] LEN_OFFSET  = 16'd2;

    // result queue, needs room for the two sync transactions
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HUNT      = 2'd0,
        PH_GOT_FIRST = 2'd1,
        PH_GOT_SYNC  = 2'd2,
        PH_READING   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
        logic       last_in_run;
    } result_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(Q_DEPTH - 1))
            nxt = '0;
        else
            nxt = ptr + PTR_W'(1);
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sync_length_frame_receiver_core.sv
`default_nettype none

// Sync/length frame receiver. Takes one received byte per transaction on the
// input channel, hunts for the sync pair 0xEA 0xEF, then passes on the sync
// pair (two output transactions from the 0xEF byte), the length byte and the
// frame body, flagging end_of_frame on the byte that brings the 16-bit
// remaining count to zero (count loaded with length - 2, wrapping as 16-bit
// unsigned). Bytes seen while hunting, and a broken sync, give no output.
// last_in_run marks the final output transaction caused by one input byte.
// Rate: one input byte per clock sustained; each result is registered into the
// queue before it reaches the output. Results go through a 4-entry queue;
// in_stall is raised while fewer than two entries are free, so the input
// stalls only when the output side is itself stalled or after a sync pair
// has not drained. in_stall and out_valid come from registers only.
module sync_length_frame_receiver_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      data_byte,
    output logic            end_of_frame,
    output logic            last_in_run
);
    import slfr_pkg::*;

    // frame tracking state
    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;

    // result queue
    result_t          q_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic       in_take;
    logic       out_take;
    logic [1:0] push_n;
    result_t    res0, res1;
    logic [15:0] base;
    logic [15:0] dec;

    assign in_stall  = (count_reg > CNT_W'(Q_DEPTH - 2));
    assign in_take   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_take  = out_valid && !out_stall;

    // count arithmetic: length byte loads length - 2, each byte from the length byte on decrements
    assign base = (phase_reg == PH_GOT_SYNC) ? ({8'h00, rx_byte} - LEN_OFFSET)
                                             : remaining_reg;
    assign dec  = base - 16'd1;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        if (in_take)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_FIRST)
                        phase_next = PH_GOT_FIRST;
                end
                PH_GOT_FIRST:
                begin
                    // any other byte, another 0xEA too, breaks the sync
                    if (rx_byte == SYNC_SECOND)
                        phase_next = PH_GOT_SYNC;
                    else
                        phase_next = PH_HUNT;
                end
                PH_GOT_SYNC, PH_READING:
                begin
                    remaining_next = dec;
                    phase_next     = (dec == 16'd0) ? PH_HUNT : PH_READING;
                end
            endcase
        end
    end

    // results of the accepted byte
    always_comb
    begin
        push_n = 2'd0;
        res0   = '{data_byte: rx_byte, end_of_frame: 1'b0, last_in_run: 1'b1};
        res1   = '{data_byte: SYNC_SECOND, end_of_frame: 1'b0, last_in_run: 1'b1};
        if (in_take)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    push_n = 2'd0;
                end
                PH_GOT_FIRST:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        push_n = 2'd2;
                        res0   = '{data_byte: SYNC_FIRST, end_of_frame: 1'b0,
                                   last_in_run: 1'b0};
                    end
                end
                PH_GOT_SYNC, PH_READING:
                begin
                    push_n = 2'd1;
                    res0   = '{data_byte: rx_byte, end_of_frame: (dec == 16'd0),
                               last_in_run: 1'b1};
                end
            endcase
        end
    end

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_n == 2'd1)
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        else if (push_n == 2'd2)
            wr_ptr_next = ptr_inc(ptr_inc(wr_ptr_reg));
        if (out_take)
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= 16'd0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    // queue storage, payload only
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            q_reg[ptr_inc(wr_ptr_reg)] <= res1;
    end

    assign data_byte    = q_reg[rd_ptr_reg].data_byte;
    assign end_of_frame = q_reg[rd_ptr_reg].end_of_frame;
    assign last_in_run  = q_reg[rd_ptr_reg].last_in_run;

endmodule

`default_nettype wire

// File: rtl/core/slfr_checker.sv
`default_nettype none

`include "assert_macros.svh"

module slfr_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] data_byte,
    input wire logic       end_of_frame,
    input wire logic       last_in_run
);
    import slfr_pkg::*;

    // a stalled result transaction keeps its payload
    `SLFR_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(data_byte) && $stable(end_of_frame) && $stable(last_in_run))

    // only the first sync byte is not last in its run
    `SLFR_ASSERT_IMP(a_first_sync_only, out_valid && !last_in_run,
        data_byte == SYNC_FIRST && !end_of_frame)

    // the first sync byte is always followed at once by the second
    `SLFR_ASSERT_NXT(a_sync_pair, out_valid && !out_stall && !last_in_run,
        out_valid && data_byte == SYNC_SECOND && last_in_run && !end_of_frame)

    // input is held off only while results are waiting
    `SLFR_ASSERT_IMP(a_stall_has_data, in_stall, out_valid)

endmodule

bind sync_length_frame_receiver_core slfr_checker u_slfr_checker (.*);

`default_nettype wire
